// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the charge integrator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pci_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse charge integrator package
// Widths, register indexes and shared record types of the charge integrator.
// ----------------------------------------------------------------------------
package pci_pkg;

  // Longest window length honored; larger register values are clamped.
  localparam int unsigned TRACE_MAX = 4096;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned IDX_W    = POS_W + 1;
  localparam int unsigned ACC_W    = 20;
  localparam int unsigned NET_W    = 33;
  localparam int unsigned PROD_W   = ACC_W + IDX_W;
  localparam int unsigned CMP_W    = 17;

  localparam logic [LEN_W-1:0] PED_LEN_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] SIG_LEN_RESET = LEN_W'(64);
  localparam logic [CMP_W-1:0] TRACE_MAX_CMP = CMP_W'(TRACE_MAX);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PEDESTAL_LENGTH = 1'b0,
    CFG_SIGNAL_LENGTH   = 1'b1
  } cfg_reg_e;

  // Window lengths in effect, already clamped
  typedef struct packed {
    logic [LEN_W-1:0] ped_len;
    logic [LEN_W-1:0] sig_len;
  } win_len_t;

  // Finished trace, handed from the accumulator to the charge stage
  typedef struct packed {
    logic signed [ACC_W-1:0] ped_sum;
    logic signed [ACC_W-1:0] win_sum;
    logic [LEN_W-1:0]        ped_len;
    logic [LEN_W-1:0]        sig_len;
    logic                    complete;
  } trace_rec_t;

  // Flow control from the charge stage back to the accumulator side
  typedef struct packed {
    logic ready;
    logic full;
  } chg_ctl_t;

  // Clamp a window length to TRACE_MAX
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if ({{(CMP_W-LEN_W){1'b0}}, len} > TRACE_MAX_CMP) begin
      res = LEN_W'(TRACE_MAX);
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/pci_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds pedestal and signal window lengths and presents them clamped.
// ----------------------------------------------------------------------------
module pci_cfg_regs import pci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  output win_len_t         len_o
);

  logic [LEN_W-1:0] ped_len_q, ped_len_d;
  logic [LEN_W-1:0] sig_len_q, sig_len_d;

  // Decode the write
  always_comb begin
    ped_len_d = ped_len_q;
    sig_len_d = sig_len_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PEDESTAL_LENGTH: ped_len_d = cfg_data_i;
        CFG_SIGNAL_LENGTH:   sig_len_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ped_len_q <= PED_LEN_RESET;
      sig_len_q <= SIG_LEN_RESET;
    end else begin
      ped_len_q <= ped_len_d;
      sig_len_q <= sig_len_d;
    end
  end

  // Clamp to the longest supported window
  assign len_o.ped_len = clamp_len(ped_len_q);
  assign len_o.sig_len = clamp_len(sig_len_q);

endmodule

// ----- rtl/core/pci_accum.sv -----
// ----------------------------------------------------------------------------
// Window accumulator
// Tracks the sample index and sums the pedestal and signal windows per trace.
// ----------------------------------------------------------------------------
module pci_accum import pci_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  input  win_len_t                   len_i,
  input  logic                       rec_ready_i,
  output trace_rec_t                 rec_o,
  output logic                       rec_valid_o
);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_OVF = IDX_W'({1'b1, {POS_W{1'b0}}});

  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    ovf_q, ovf_d;
  logic signed [ACC_W-1:0] ped_acc_q, ped_acc_d;
  logic signed [ACC_W-1:0] win_acc_q, win_acc_d;
  trace_rec_t              rec_q, rec_d;
  logic                    rec_valid_q, rec_valid_d;

  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        ped_end;
  logic [IDX_W-1:0]        win_end;
  logic signed [ACC_W-1:0] ext;
  logic signed [ACC_W-1:0] ped_sum;
  logic signed [ACC_W-1:0] win_sum;
  logic                    in_ped;
  logic                    in_win;

  // Classify the sample against both windows
  assign idx     = ovf_q ? IDX_OVF : {1'b0, pos_q};
  assign ped_end = {1'b0, len_i.ped_len};
  assign win_end = ped_end + {1'b0, len_i.sig_len};
  assign ext     = {{(ACC_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign in_ped  = idx < ped_end;
  assign in_win  = !in_ped && (idx < win_end);
  assign ped_sum = in_ped ? ped_acc_q + ext : ped_acc_q;
  assign win_sum = in_win ? win_acc_q + ext : win_acc_q;

  // Advance the index, update sums, clear at trace end
  always_comb begin
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    ped_acc_d = ped_acc_q;
    win_acc_d = win_acc_q;
    if (take_i) begin
      if (last_i) begin
        pos_d     = '0;
        ovf_d     = 1'b0;
        ped_acc_d = '0;
        win_acc_d = '0;
      end else begin
        ped_acc_d = ped_sum;
        win_acc_d = win_sum;
        if (pos_q == POS_MAX) begin
          ovf_d = 1'b1;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  // Load a finished trace, drop it once the charge stage takes it
  always_comb begin
    rec_d       = rec_q;
    rec_valid_d = rec_valid_q;
    if (rec_valid_q && rec_ready_i) begin
      rec_valid_d = 1'b0;
    end
    if (take_i && last_i) begin
      rec_valid_d      = 1'b1;
      rec_d.ped_sum    = ped_sum;
      rec_d.win_sum    = win_sum;
      rec_d.ped_len    = len_i.ped_len;
      rec_d.sig_len    = len_i.sig_len;
      rec_d.complete   = (idx + IDX_W'(1)) >= win_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      ped_acc_q   <= '0;
      win_acc_q   <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      ped_acc_q   <= ped_acc_d;
      win_acc_q   <= win_acc_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o       = rec_q;
  assign rec_valid_o = rec_valid_q;

endmodule

// ----- rtl/core/pci_charge.sv -----
// ----------------------------------------------------------------------------
// Net charge stage
// Scales both sums by the opposite window length and subtracts them.
// ----------------------------------------------------------------------------
module pci_charge import pci_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  trace_rec_t              rec_i,
  input  logic                    rec_valid_i,
  output chg_ctl_t                ctl_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] pedestal_sum_o,
  output logic signed [ACC_W-1:0] window_sum_o,
  output logic signed [NET_W-1:0] net_charge_o,
  output logic                    window_complete_o
);

  logic signed [PROD_W-1:0] prod_ped;
  logic signed [PROD_W-1:0] prod_win;

  // Product stage
  logic                    m_valid_q, m_valid_d;
  logic signed [NET_W-1:0] m_ped_prod_q;
  logic signed [NET_W-1:0] m_win_prod_q;
  logic signed [ACC_W-1:0] m_ped_sum_q;
  logic signed [ACC_W-1:0] m_win_sum_q;
  logic                    m_complete_q;

  // Output stage
  logic                    o_valid_q, o_valid_d;
  logic signed [ACC_W-1:0] o_ped_sum_q;
  logic signed [ACC_W-1:0] o_win_sum_q;
  logic signed [NET_W-1:0] o_net_q;
  logic                    o_complete_q;

  logic o_free;
  logic m_adv;
  logic rec_take;

  // Handshake between stages
  assign o_free   = !o_valid_q || !out_stall_i;
  assign m_adv    = m_valid_q && o_free;
  assign rec_take = rec_valid_i && (!m_valid_q || o_free);

  // Cross-multiply: pedestal sum by S, window sum by P
  assign prod_ped = $signed(rec_i.ped_sum) * $signed({1'b0, rec_i.sig_len});
  assign prod_win = $signed(rec_i.win_sum) * $signed({1'b0, rec_i.ped_len});

  always_comb begin
    m_valid_d = m_valid_q;
    if (rec_take) begin
      m_valid_d = 1'b1;
    end else if (m_adv) begin
      m_valid_d = 1'b0;
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    if (m_adv) begin
      o_valid_d = 1'b1;
    end else if (o_valid_q && !out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Capture products
  always_ff @(posedge clk_i) begin
    if (rec_take) begin
      m_ped_prod_q <= prod_ped[NET_W-1:0];
      m_win_prod_q <= prod_win[NET_W-1:0];
      m_ped_sum_q  <= rec_i.ped_sum;
      m_win_sum_q  <= rec_i.win_sum;
      m_complete_q <= rec_i.complete;
    end
  end

  // Subtract into the result register
  always_ff @(posedge clk_i) begin
    if (m_adv) begin
      o_ped_sum_q  <= m_ped_sum_q;
      o_win_sum_q  <= m_win_sum_q;
      o_net_q      <= m_ped_prod_q - m_win_prod_q;
      o_complete_q <= m_complete_q;
    end
  end

  // Full only when both stages hold a trace and the output cannot drain
  assign ctl_o.ready       = !m_valid_q || o_free;
  assign ctl_o.full        = m_valid_q && o_valid_q && out_stall_i;
  assign out_valid_o       = o_valid_q;
  assign pedestal_sum_o    = o_ped_sum_q;
  assign window_sum_o      = o_win_sum_q;
  assign net_charge_o      = o_net_q;
  assign window_complete_o = o_complete_q;

endmodule

// ----- rtl/core/pulse_charge_integrator.sv -----
// ----------------------------------------------------------------------------
// Pulse charge integrator
// Pedestal-subtracted window charge of signed digitizer traces.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the input is not stalled. Each
// taken sample updates the running pedestal and window sum registers; a sample
// flagged as the last of its trace produces one request that reaches the
// output after passing the trace register (loaded at the edge that took it),
// the product register (two 20x14 multipliers) and the result register. Up
// to three finished traces are held in flight; the input stalls only while
// all three are held and the output is stalled.
`include "assert_macros.svh"

module pulse_charge_integrator import pci_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [LEN_W-1:0]           cfg_data_i,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_of_trace_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ACC_W-1:0]    pedestal_sum_o,
  output logic signed [ACC_W-1:0]    window_sum_o,
  output logic signed [NET_W-1:0]    net_charge_o,
  output logic                       window_complete_o
);

  win_len_t   len;
  trace_rec_t rec;
  logic       rec_valid;
  chg_ctl_t   chg_ctl;
  logic       take;

  // Stall only when every stage holds a trace and the output is stalled
  assign in_stall_o = rec_valid && chg_ctl.full;
  assign take       = in_valid_i && !in_stall_o;

  pci_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .len_o       (len)
  );

  pci_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .sample_i    (sample_i),
    .last_i      (last_of_trace_i),
    .len_i       (len),
    .rec_ready_i (chg_ctl.ready),
    .rec_o       (rec),
    .rec_valid_o (rec_valid)
  );

  pci_charge u_charge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_i             (rec),
    .rec_valid_i       (rec_valid),
    .ctl_o             (chg_ctl),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pedestal_sum_o    (pedestal_sum_o),
    .window_sum_o      (window_sum_o),
    .net_charge_o      (net_charge_o),
    .window_complete_o (window_complete_o)
  );

  // Input stall implies a full result register
  `ASSERT_IMPLIES(a_stall_needs_full_out, clk_i, rst_ni, in_stall_o, out_valid_o, "stall with empty output")
  // A taken trace end loads the trace register
  `ASSERT_NEXT(a_last_loads_rec, clk_i, rst_ni, take && last_of_trace_i, rec_valid, "trace end lost")
  // A trace record not taken holds its contents
  `ASSERT_NEXT(a_rec_holds, clk_i, rst_ni, rec_valid && !chg_ctl.ready, rec_valid && $stable(rec), "trace record changed while waiting")

endmodule

// ----- tb/tb_pulse_charge_integrator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse charge integrator testbench
// Drives signed sample traces and window length writes into the integrator,
// predicts pedestal sum, window sum, net charge and the completion flag of
// every finished trace, and compares each result request in order.
// ----------------------------------------------------------------------------
module tb_pulse_charge_integrator;
  import pci_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int NUM_FIXED    = 9;

  // One finished trace as seen on the result port
  typedef struct {
    logic signed [ACC_W-1:0] ped_sum;
    logic signed [ACC_W-1:0] win_sum;
    logic signed [NET_W-1:0] net;
    logic                    complete;
  } charge_t;

  // Trace accumulator model plus the queue of charges still to come out
  class charge_scoreboard;
    logic [LEN_W-1:0]        ped_len;
    logic [LEN_W-1:0]        sig_len;
    logic [LEN_W-1:0]        position;
    bit                      position_sat;
    logic signed [ACC_W-1:0] baseline;
    logic signed [ACC_W-1:0] window;
    charge_t                 expected_charges[$];
    int                      mismatches;

    function new();
      ped_len    = PED_LEN_RESET;
      sig_len    = SIG_LEN_RESET;
      mismatches = 0;
      clear_trace();
    endfunction

    function void clear_trace();
      position     = '0;
      position_sat = 1'b0;
      baseline     = '0;
      window       = '0;
    endfunction

    function void set_length(cfg_reg_e which, logic [LEN_W-1:0] value);
      case (which)
        CFG_PEDESTAL_LENGTH: ped_len = value;
        CFG_SIGNAL_LENGTH:   sig_len = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_charges.size();
    endfunction

    // Accumulate one accepted sample; queue a charge at the trace end
    function void integrate_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
      logic [LEN_W-1:0] p;
      logic [LEN_W-1:0] s;
      logic [LEN_W:0]   idx;
      longint           net_full;
      charge_t          c;
      p   = (ped_len > TRACE_MAX) ? LEN_W'(TRACE_MAX) : ped_len;
      s   = (sig_len > TRACE_MAX) ? LEN_W'(TRACE_MAX) : sig_len;
      idx = position_sat ? (LEN_W+1)'(8192) : {1'b0, position};
      if (idx < p) begin
        baseline = baseline + smp;
      end else if (idx < p + s) begin
        window = window + smp;
      end
      // saturate the position once it reaches the top of its range
      if (position == {LEN_W{1'b1}}) begin
        position_sat = 1'b1;
      end else begin
        position = position + 1'b1;
      end
      if (last) begin
        net_full   = longint'(baseline) * longint'(s) - longint'(window) * longint'(p);
        c.ped_sum  = baseline;
        c.win_sum  = window;
        c.net      = net_full[NET_W-1:0];
        c.complete = ((idx + 1'b1) >= (p + s));
        expected_charges.push_back(c);
        clear_trace();
      end
    endfunction

    // Compare one result request against the oldest queued charge
    function void compare_charge(logic signed [ACC_W-1:0] ped, logic signed [ACC_W-1:0] win,
                                 logic signed [NET_W-1:0] net, logic cpl);
      charge_t want;
      if (expected_charges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: ped=%0d win=%0d net=%0d complete=%0b",
                   ped, win, net, cpl);
        end
        return;
      end
      want = expected_charges.pop_front();
      if (want.ped_sum !== ped || want.win_sum !== win || want.net !== net ||
          want.complete !== cpl) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected ped=%0d win=%0d net=%0d complete=%0b",
                   $realtime, want.ped_sum, want.win_sum, want.net, want.complete);
          $display("                 actual   ped=%0d win=%0d net=%0d complete=%0b",
                   ped, win, net, cpl);
        end
      end
    endfunction
  endclass

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_we_i        = 1'b0;
  logic [0:0]                 cfg_index_i     = CFG_PEDESTAL_LENGTH;
  logic [LEN_W-1:0]           cfg_data_i      = '0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i        = '0;
  logic                       last_of_trace_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic signed [ACC_W-1:0]    pedestal_sum_o;
  logic signed [ACC_W-1:0]    window_sum_o;
  logic signed [NET_W-1:0]    net_charge_o;
  logic                       window_complete_o;

  charge_scoreboard charges = new();

  int sent_items    = 0;
  int cycle_count   = 0;
  bit tx_burst      = 1'b0;
  bit rx_burst      = 1'b0;
  bit hold_request  = 1'b0;
  int fixed_ped[NUM_FIXED] = '{1, 0, 3, 0, 8191, 2, 4097, 16, 7};
  int fixed_sig[NUM_FIXED] = '{0, 0, 5, 1, 2, 8191, 4097, 64, 9};

  pulse_charge_integrator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .last_of_trace_i   (last_of_trace_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pedestal_sum_o    (pedestal_sum_o),
    .window_sum_o      (window_sum_o),
    .net_charge_o      (net_charge_o),
    .window_complete_o (window_complete_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Observe accepted samples, register writes and result requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        charges.integrate_sample(sample_i, last_of_trace_i);
      end
      if (cfg_we_i) begin
        charges.set_length(cfg_reg_e'(cfg_index_i), cfg_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        charges.compare_charge(pedestal_sum_o, window_sum_o, net_charge_o,
                               window_complete_o);
      end
    end
  end

  // Result side: random stall before each request, long hold on demand
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_burst = !rx_burst;
      end
      w = rx_burst ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      forever begin
        @(posedge clk_i);
        if (out_valid_o) break;
        if (hold_request) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          out_stall_i  <= 1'b0;
          hold_request = 1'b0;
        end
      end
    end
  end

  // Offer one sample after a random gap and hold it until taken
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= smp;
    last_of_trace_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  // Send a whole trace of random samples, extremes mixed in
  task automatic send_trace(int len);
    logic signed [SAMPLE_W-1:0] smp;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        smp = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      end else begin
        smp = SAMPLE_W'($urandom_range(0, 255));
      end
      send_sample(smp, i == len - 1);
    end
  endtask

  // Drop valid and wait until every queued charge has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (charges.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both window lengths on back-to-back edges
  task automatic program_lengths(int ped, int sig);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PEDESTAL_LENGTH;
    cfg_data_i  <= LEN_W'(ped);
    @(posedge clk_i);
    cfg_index_i <= CFG_SIGNAL_LENGTH;
    cfg_data_i  <= LEN_W'(sig);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int phase;
    int pl;
    int sl;
    int pe;
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample trace under the reset lengths
    send_sample(-8'sd128, 1'b1);
    drain();
    // exact fit of both windows, then one sample past the window
    program_lengths(2, 3);
    send_sample(8'sd127, 1'b0);
    send_sample(8'sd127, 1'b0);
    send_sample(-8'sd128, 1'b0);
    send_sample(-8'sd128, 1'b0);
    send_sample(-8'sd128, 1'b1);
    for (int i = 1; i <= 6; i++) begin
      send_sample(SAMPLE_W'(i), i == 6);
    end
    drain();
    // no pedestal window: net charge stays zero
    program_lengths(0, 3);
    send_sample(8'sd5, 1'b0);
    send_sample(-8'sd7, 1'b0);
    send_sample(8'sd9, 1'b1);
    drain();
    // empty signal window, complete and short traces
    program_lengths(2, 0);
    send_sample(8'sd100, 1'b0);
    send_sample(-8'sd100, 1'b1);
    send_sample(8'sd7, 1'b1);
    drain();
    // change the lengths in the middle of an open trace
    send_sample(8'sd3, 1'b0);
    send_sample(8'sd4, 1'b0);
    drain();
    program_lengths(1, 2);
    send_sample(-8'sd5, 1'b1);
    drain();

    // random traces over a series of window settings
    phase      = 0;
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (phase < NUM_FIXED) begin
        pl = fixed_ped[phase];
        sl = fixed_sig[phase];
      end else begin
        pl = $urandom_range(0, 12);
        sl = $urandom_range(0, 20);
        if ($urandom_range(0, 7) == 0) pl = $urandom_range(4097, 8191);
      end
      program_lengths(pl, sl);
      // fill the block while the result side holds off
      if (phase == 3) begin
        hold_request = 1'b1;
        tx_burst     = 1'b1;
        for (int t = 0; t < 40; t++) begin
          send_trace($urandom_range(1, 2));
        end
      end
      pe = ((pl > TRACE_MAX) ? TRACE_MAX : pl) + ((sl > TRACE_MAX) ? TRACE_MAX : sl);
      for (int t = 0; t < 12; t++) begin
        if (pe > 100) begin
          len = $urandom_range(1, 48);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: len = (pe > 0) ? pe : 1;
            4:          len = (pe > 1) ? pe - 1 : 1;
            5:          len = pe + 1;
            9:          len = 1;
            default:    len = $urandom_range(1, pe + 6);
          endcase
        end
        tx_burst = ($urandom_range(0, 3) == 0);
        send_trace(len);
      end
      // leave a trace open across the next length change
      if ($urandom_range(0, 2) == 0) begin
        for (int i = $urandom_range(1, 5); i > 0; i--) begin
          send_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b0);
        end
      end
      drain();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (charges.mismatches == 0 && charges.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pci_pkg.sv
rtl/core/pci_cfg_regs.sv
rtl/core/pci_accum.sv
rtl/core/pci_charge.sv
rtl/core/pulse_charge_integrator.sv
tb/tb_pulse_charge_integrator.sv
